// ===== hdl/bilinear_field_sampler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Bilinear field sampler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_FIELD_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_FIELD_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BFS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear field sampler package
// Field widths, defaults and shared types.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int FIELD_COUNT_DEF = 4;
    localparam int GRID_SIDE_DEF   = 32;

    localparam int FIELD_W = 2;
    localparam int ADDR_W  = 10;
    localparam int VALUE_W = 16;
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } stage_ctl_t;

endpackage

// ===== hdl/bfs_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Write and sample requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfs_in_if;
    import bfs_pkg::*;

    logic                       valid;
    logic                       ready;
    op_t                        op;
    logic [FIELD_W-1:0]         field_index;
    logic [ADDR_W-1:0]          cell_addr;
    logic [VALUE_W-1:0]         cell_value;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_scale;

    modport source (
        output valid, op, field_index, cell_addr, cell_value, coord_x, coord_y,
               coord_scale,
        input  ready
    );

    modport sink (
        input  valid, op, field_index, cell_addr, cell_value, coord_x, coord_y,
               coord_scale,
        output ready
    );

endinterface

// ===== hdl/bfs_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Blended sample values with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfs_out_if;
    import bfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] sample_value;

    modport source (
        output valid, sample_value,
        input  ready
    );

    modport sink (
        input  valid, sample_value,
        output ready
    );

endinterface

// ===== hdl/bilinear_field_sampler_top.sv =====
// ----------------------------------------------------------------------------
// Bilinear field sampler
// Grid store with streaming bilinear lookups on scaled Q16.16 coordinates.
// ----------------------------------------------------------------------------
// The block keeps FIELD_COUNT grids of GRID_SIDE x GRID_SIDE 16-bit words and
// takes one request transaction per cycle on req while rsp does not stall,
// writes and samples freely mixed. A write stores one word and gives no
// result; a sample gives one result on rsp from the output register, and every
// result comes back in request order. The rate of one transaction per cycle
// is set by the grid store, held as two identical copies, each written at one
// address and read at two, so that all four neighbours of a sample are read
// in one cycle. The work runs through nine register stages: five for the
// coordinate path (scale multiply, rounding, saturation and absolute value,
// reciprocal estimate of the cell, wrap), one for the store, three for the
// two weighting passes and the saturating sum, which is also the output
// register. Each stage advances whenever it is empty or its successor moves,
// so bubbles close up and a stall on rsp holds every stage without loss.
// Writes apply in the store stage, in order with the samples around them, so
// a sample always sees every write accepted before it. The store is not
// cleared after reset; a word that was never written reads as an unknown
// value, and no start-up pass is needed before the first transaction.
// ----------------------------------------------------------------------------
module bilinear_field_sampler_top #(
    parameter int FIELD_COUNT = bfs_pkg::FIELD_COUNT_DEF,
    parameter int GRID_SIDE   = bfs_pkg::GRID_SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bfs_in_if.sink      req,
    bfs_out_if.source   rsp
);
    import bfs_pkg::*;

    localparam int CELL_IW  = $clog2(GRID_SIDE);
    localparam int CELL_AW  = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int FIELD_IW = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;

    // coordinate pipeline to store stage
    stage_ctl_t          coord_ctl;
    logic                fetch_ready;
    logic [FIELD_IW-1:0] field;
    logic [CELL_AW-1:0]  waddr;
    logic [VALUE_W-1:0]  wvalue;
    logic [CELL_IW-1:0]  fx, kx, fy, ky;
    logic [FRAC_W-1:0]   wcx, wcy;

    // store stage to blend pipeline
    logic                fetch_valid;
    logic                blend_ready;
    logic [VALUE_W-1:0]  s00, s01, s10, s11;
    logic [FRAC_W-1:0]   fetch_wcx, fetch_wcy;

    // Scale, round, saturate and wrap both coordinates; carry writes alongside.
    bfs_coord #(
        .FIELD_COUNT (FIELD_COUNT),
        .GRID_SIDE   (GRID_SIDE)
    ) u_coord (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .ctl        (coord_ctl),
        .down_ready (fetch_ready),
        .field      (field),
        .waddr      (waddr),
        .wvalue     (wvalue),
        .fx         (fx),
        .kx         (kx),
        .fy         (fy),
        .ky         (ky),
        .wcx        (wcx),
        .wcy        (wcy)
    );

    // Apply writes, read the four neighbours of each sample.
    bfs_fetch #(
        .FIELD_COUNT (FIELD_COUNT),
        .GRID_SIDE   (GRID_SIDE)
    ) u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (coord_ctl),
        .up_ready   (fetch_ready),
        .field      (field),
        .waddr      (waddr),
        .wvalue     (wvalue),
        .fx         (fx),
        .kx         (kx),
        .fy         (fy),
        .ky         (ky),
        .wcx        (wcx),
        .wcy        (wcy),
        .valid      (fetch_valid),
        .down_ready (blend_ready),
        .s00        (s00),
        .s01        (s01),
        .s10        (s10),
        .s11        (s11),
        .wcx_out    (fetch_wcx),
        .wcy_out    (fetch_wcy)
    );

    // Weight along y, then along x, then sum and clamp into the output register.
    bfs_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (fetch_valid),
        .up_ready (blend_ready),
        .s00      (s00),
        .s01      (s01),
        .s10      (s10),
        .s11      (s11),
        .wcx      (fetch_wcx),
        .wcy      (fetch_wcy),
        .rsp      (rsp)
    );

endmodule

// ===== hdl/bfs_coord.sv =====
// ----------------------------------------------------------------------------
// Coordinate pipeline
// Scales, rounds, saturates and folds coordinates into wrapped cell indices.
// ----------------------------------------------------------------------------
`include "bilinear_field_sampler_top_defines.svh"

module bfs_coord #(
    parameter int   FIELD_COUNT = bfs_pkg::FIELD_COUNT_DEF,
    parameter int   GRID_SIDE   = bfs_pkg::GRID_SIDE_DEF,
    localparam int  CELL_IW     = $clog2(GRID_SIDE),
    localparam int  CELL_AW     = $clog2(GRID_SIDE * GRID_SIDE),
    localparam int  FIELD_IW    = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bfs_in_if.sink                        req,
    output bfs_pkg::stage_ctl_t           ctl,
    input  logic                          down_ready,
    output logic [FIELD_IW-1:0]           field,
    output logic [CELL_AW-1:0]            waddr,
    output logic [bfs_pkg::VALUE_W-1:0]   wvalue,
    output logic [CELL_IW-1:0]            fx,
    output logic [CELL_IW-1:0]            kx,
    output logic [CELL_IW-1:0]            fy,
    output logic [CELL_IW-1:0]            ky,
    output logic [bfs_pkg::FRAC_W-1:0]    wcx,
    output logic [bfs_pkg::FRAC_W-1:0]    wcy
);
    import bfs_pkg::*;

    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int RECIP_W    = FRAC_W + 1;
    localparam int WQ_W       = ADDR_W + RECIP_W;
    localparam int WM_W       = ADDR_W + 1 + RECIP_W + 1;
    localparam int CI_W       = COORD_W - 1 - FRAC_W;
    localparam int CQ_W       = CI_W + RECIP_W;
    localparam int CM_W       = CI_W + CELL_IW + 1;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int RR_W       = COORD_W + 2;
    localparam int FIELD_SPAN = 1 << FIELD_W;

    localparam logic [RECIP_W-1:0] RECIP_CELLS = RECIP_W'((1 << FRAC_W) / GRID_CELLS);
    localparam logic [RECIP_W-1:0] RECIP_SIDE  = RECIP_W'((1 << FRAC_W) / GRID_SIDE);
    localparam logic [4:0]         FC5         = 5'(FIELD_COUNT);
    localparam logic signed [RR_W-1:0] RR_MAX  = RR_W'(34'sh07FFFFFFF);
    localparam logic [COORD_W-2:0] ABS_MAX     = '1;

    function automatic logic [FIELD_IW-1:0] wrap_field(input logic [FIELD_W-1:0] f);
        logic [4:0] r;
        r = 5'(f);
        for (int i = 0; i < FIELD_SPAN - 1; i++) begin
            if (r >= FC5) begin
                r = r - FC5;
            end
        end
        return FIELD_IW'(r);
    endfunction

    function automatic logic product_ovf(input logic signed [PROD_W-1:0] p);
        return !((&p[PROD_W-1:47]) || !(|p[PROD_W-1:47]));
    endfunction

    // Round half up on the Q16.16 product, negative values biased down by one.
    function automatic logic signed [RR_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic [49:0] pm;
        pm = p[49:0] - 50'(p[PROD_W-1]);
        return RR_W'($signed(pm[49:16])) + RR_W'(pm[15]);
    endfunction

    function automatic logic [COORD_W-2:0] sat_abs(input logic ovf,
                                                   input logic signed [RR_W-1:0] rr);
        logic signed [RR_W-1:0] neg;
        neg = -rr;
        if (ovf || rr >= RR_MAX || rr <= -RR_MAX) begin
            return ABS_MAX;
        end
        if (rr < 0) begin
            return (COORD_W-1)'(neg);
        end
        return (COORD_W-1)'(rr);
    endfunction

    function automatic logic [CELL_IW-1:0] floor_cell(input logic [CI_W-1:0] ci,
                                                      input logic [CI_W-1:0] q);
        logic [CM_W-1:0] d;
        d = CM_W'(ci) - CM_W'(q) * CM_W'(GRID_SIDE);
        if (d >= CM_W'(GRID_SIDE)) begin
            d = d - CM_W'(GRID_SIDE);
        end
        return CELL_IW'(d);
    endfunction

    function automatic logic [CELL_IW-1:0] ceil_cell(input logic [CELL_IW-1:0] f,
                                                     input logic nz);
        logic [CELL_IW:0] k;
        k = (CELL_IW+1)'(f) + (CELL_IW+1)'(nz);
        if (k == (CELL_IW+1)'(GRID_SIDE)) begin
            k = '0;
        end
        return CELL_IW'(k);
    endfunction

    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: multiply
    op_t                       op1_reg;
    logic [FIELD_IW-1:0]       fld1_reg;
    logic [ADDR_W-1:0]         addr1_reg;
    logic [VALUE_W-1:0]        val1_reg;
    logic [WQ_W-1:0]           wq1_reg;
    logic signed [PROD_W-1:0]  px1_reg, py1_reg;
    logic signed [PROD_W-1:0]  px_next, py_next;

    // stage 2: round
    op_t                       op2_reg;
    logic [FIELD_IW-1:0]       fld2_reg;
    logic [VALUE_W-1:0]        val2_reg;
    logic [CELL_AW-1:0]        wa2_reg;
    logic                      ovfx2_reg, ovfy2_reg;
    logic signed [RR_W-1:0]    rrx2_reg, rry2_reg;
    logic [CELL_AW-1:0]        wa_next;
    logic [WM_W-1:0]           wdiff;

    // stage 3: saturate and fold sign
    op_t                       op3_reg;
    logic [FIELD_IW-1:0]       fld3_reg;
    logic [VALUE_W-1:0]        val3_reg;
    logic [CELL_AW-1:0]        wa3_reg;
    logic [COORD_W-2:0]        cx3_reg, cy3_reg;

    // stage 4: cell quotient estimate
    op_t                       op4_reg;
    logic [FIELD_IW-1:0]       fld4_reg;
    logic [VALUE_W-1:0]        val4_reg;
    logic [CELL_AW-1:0]        wa4_reg;
    logic [CI_W-1:0]           cix4_reg, ciy4_reg, qx4_reg, qy4_reg;
    logic [FRAC_W-1:0]         frx4_reg, fry4_reg;
    logic [CQ_W-1:0]           qx_prod, qy_prod;

    // stage 5: wrapped cells
    op_t                       op5_reg;
    logic [FIELD_IW-1:0]       fld5_reg;
    logic [VALUE_W-1:0]        val5_reg;
    logic [CELL_AW-1:0]        wa5_reg;
    logic [CELL_IW-1:0]        fx5_reg, kx5_reg, fy5_reg, ky5_reg;
    logic [CELL_IW-1:0]        fx_next, fy_next;
    logic [FRAC_W-1:0]         wcx5_reg, wcy5_reg;

    assign en5       = !v5_reg || down_ready;
    assign en4       = !v4_reg || en5;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign req.ready = en1;

    assign px_next = PROD_W'(req.coord_x) * PROD_W'(req.coord_scale);
    assign py_next = PROD_W'(req.coord_y) * PROD_W'(req.coord_scale);

    // Write address modulo grid size: reciprocal estimate, one correction.
    always_comb
    begin
        wdiff = WM_W'(addr1_reg) - WM_W'(wq1_reg[WQ_W-1:FRAC_W]) * WM_W'(GRID_CELLS);
        if (wdiff >= WM_W'(GRID_CELLS)) begin
            wdiff = wdiff - WM_W'(GRID_CELLS);
        end
        wa_next = CELL_AW'(wdiff);
    end

    assign qx_prod = CQ_W'(cx3_reg[COORD_W-2:FRAC_W]) * CQ_W'(RECIP_SIDE);
    assign qy_prod = CQ_W'(cy3_reg[COORD_W-2:FRAC_W]) * CQ_W'(RECIP_SIDE);

    assign fx_next = floor_cell(cix4_reg, qx4_reg);
    assign fy_next = floor_cell(ciy4_reg, qy4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= req.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) begin
            op1_reg   <= req.op;
            fld1_reg  <= wrap_field(req.field_index);
            addr1_reg <= req.cell_addr;
            val1_reg  <= req.cell_value;
            wq1_reg   <= WQ_W'(req.cell_addr) * WQ_W'(RECIP_CELLS);
            px1_reg   <= px_next;
            py1_reg   <= py_next;
        end
        if (en2) begin
            op2_reg   <= op1_reg;
            fld2_reg  <= fld1_reg;
            val2_reg  <= val1_reg;
            wa2_reg   <= wa_next;
            ovfx2_reg <= product_ovf(px1_reg);
            ovfy2_reg <= product_ovf(py1_reg);
            rrx2_reg  <= round_q16(px1_reg);
            rry2_reg  <= round_q16(py1_reg);
        end
        if (en3) begin
            op3_reg  <= op2_reg;
            fld3_reg <= fld2_reg;
            val3_reg <= val2_reg;
            wa3_reg  <= wa2_reg;
            cx3_reg  <= sat_abs(ovfx2_reg, rrx2_reg);
            cy3_reg  <= sat_abs(ovfy2_reg, rry2_reg);
        end
        if (en4) begin
            op4_reg  <= op3_reg;
            fld4_reg <= fld3_reg;
            val4_reg <= val3_reg;
            wa4_reg  <= wa3_reg;
            cix4_reg <= cx3_reg[COORD_W-2:FRAC_W];
            ciy4_reg <= cy3_reg[COORD_W-2:FRAC_W];
            frx4_reg <= cx3_reg[FRAC_W-1:0];
            fry4_reg <= cy3_reg[FRAC_W-1:0];
            qx4_reg  <= qx_prod[FRAC_W+CI_W-1:FRAC_W];
            qy4_reg  <= qy_prod[FRAC_W+CI_W-1:FRAC_W];
        end
        if (en5) begin
            op5_reg  <= op4_reg;
            fld5_reg <= fld4_reg;
            val5_reg <= val4_reg;
            wa5_reg  <= wa4_reg;
            fx5_reg  <= fx_next;
            fy5_reg  <= fy_next;
            kx5_reg  <= ceil_cell(fx_next, |frx4_reg);
            ky5_reg  <= ceil_cell(fy_next, |fry4_reg);
            wcx5_reg <= frx4_reg;
            wcy5_reg <= fry4_reg;
        end
    end

    assign ctl    = '{valid: v5_reg, op: op5_reg};
    assign field  = fld5_reg;
    assign waddr  = wa5_reg;
    assign wvalue = val5_reg;
    assign fx     = fx5_reg;
    assign kx     = kx5_reg;
    assign fy     = fy5_reg;
    assign ky     = ky5_reg;
    assign wcx    = wcx5_reg;
    assign wcy    = wcy5_reg;

    `BFS_ASSERT_IMPL(a_cells_in_grid, v5_reg && op5_reg == OP_SAMPLE, fx5_reg < GRID_SIDE && kx5_reg < GRID_SIDE && fy5_reg < GRID_SIDE && ky5_reg < GRID_SIDE, "cell index outside grid")
    `BFS_ASSERT_IMPL(a_waddr_in_grid, v5_reg && op5_reg == OP_WRITE, wa5_reg < GRID_CELLS, "write address outside grid")
    `BFS_ASSERT_IMPL(a_integer_coord, v5_reg && op5_reg == OP_SAMPLE && wcx5_reg == '0, kx5_reg == fx5_reg, "ceiling cell moved on integer coordinate")

endmodule

// ===== hdl/bfs_fetch.sv =====
// ----------------------------------------------------------------------------
// Grid fetch stage
// Holds the grid store in two copies; applies writes, reads four neighbours.
// ----------------------------------------------------------------------------
`include "bilinear_field_sampler_top_defines.svh"

module bfs_fetch #(
    parameter int   FIELD_COUNT = bfs_pkg::FIELD_COUNT_DEF,
    parameter int   GRID_SIDE   = bfs_pkg::GRID_SIDE_DEF,
    localparam int  CELL_IW     = $clog2(GRID_SIDE),
    localparam int  CELL_AW     = $clog2(GRID_SIDE * GRID_SIDE),
    localparam int  FIELD_IW    = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfs_pkg::stage_ctl_t           ctl,
    output logic                          up_ready,
    input  logic [FIELD_IW-1:0]           field,
    input  logic [CELL_AW-1:0]            waddr,
    input  logic [bfs_pkg::VALUE_W-1:0]   wvalue,
    input  logic [CELL_IW-1:0]            fx,
    input  logic [CELL_IW-1:0]            kx,
    input  logic [CELL_IW-1:0]            fy,
    input  logic [CELL_IW-1:0]            ky,
    input  logic [bfs_pkg::FRAC_W-1:0]    wcx,
    input  logic [bfs_pkg::FRAC_W-1:0]    wcy,
    output logic                          valid,
    input  logic                          down_ready,
    output logic [bfs_pkg::VALUE_W-1:0]   s00,
    output logic [bfs_pkg::VALUE_W-1:0]   s01,
    output logic [bfs_pkg::VALUE_W-1:0]   s10,
    output logic [bfs_pkg::VALUE_W-1:0]   s11,
    output logic [bfs_pkg::FRAC_W-1:0]    wcx_out,
    output logic [bfs_pkg::FRAC_W-1:0]    wcy_out
);
    import bfs_pkg::*;

    localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int STORE_WORDS = FIELD_COUNT * GRID_CELLS;
    localparam int STORE_AW    = $clog2(STORE_WORDS);

    // Row fx copy serves (fx,fy) and (fx,ky); row kx copy serves the others.
    logic [VALUE_W-1:0] mem_f [STORE_WORDS];
    logic [VALUE_W-1:0] mem_k [STORE_WORDS];

    logic                en;
    logic                v_reg;
    logic                do_write, do_read;
    logic [STORE_AW-1:0] base, row_f, row_k, wr_addr;
    logic [STORE_AW-1:0] a_ff, a_fk, a_kf, a_kk;
    logic [VALUE_W-1:0]  s00_reg, s01_reg, s10_reg, s11_reg;
    logic [FRAC_W-1:0]   wcx_reg, wcy_reg;

    assign en       = !v_reg || down_ready;
    assign up_ready = en;
    assign do_write = en && ctl.valid && ctl.op == OP_WRITE;
    assign do_read  = en && ctl.valid && ctl.op == OP_SAMPLE;

    assign base    = STORE_AW'(field) * STORE_AW'(GRID_CELLS);
    assign row_f   = base + STORE_AW'(fx) * STORE_AW'(GRID_SIDE);
    assign row_k   = base + STORE_AW'(kx) * STORE_AW'(GRID_SIDE);
    assign a_ff    = row_f + STORE_AW'(fy);
    assign a_fk    = row_f + STORE_AW'(ky);
    assign a_kf    = row_k + STORE_AW'(fy);
    assign a_kk    = row_k + STORE_AW'(ky);
    assign wr_addr = base + STORE_AW'(waddr);

    always_ff @(posedge clk)
    begin
        if (do_write) begin
            mem_f[wr_addr] <= wvalue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write) begin
            mem_k[wr_addr] <= wvalue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read) begin
            s00_reg <= mem_f[a_ff];
            s01_reg <= mem_f[a_fk];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read) begin
            s10_reg <= mem_k[a_kf];
            s11_reg <= mem_k[a_kk];
            wcx_reg <= wcx;
            wcy_reg <= wcy;
        end
    end

    // Writes retire here; only samples move on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= ctl.valid && ctl.op == OP_SAMPLE;
        end
    end

    assign valid   = v_reg;
    assign s00     = s00_reg;
    assign s01     = s01_reg;
    assign s10     = s10_reg;
    assign s11     = s11_reg;
    assign wcx_out = wcx_reg;
    assign wcy_out = wcy_reg;

    `BFS_ASSERT_NEXT(a_fetch_hold, v_reg && !down_ready, $stable(s00_reg) && $stable(s01_reg) && $stable(s10_reg) && $stable(s11_reg), "read data changed under stall")

endmodule

// ===== hdl/bfs_blend.sv =====
// ----------------------------------------------------------------------------
// Blend pipeline
// Weights the four neighbours in two rounded passes and sums with saturation.
// ----------------------------------------------------------------------------
module bfs_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    output logic                          up_ready,
    input  logic [bfs_pkg::VALUE_W-1:0]   s00,
    input  logic [bfs_pkg::VALUE_W-1:0]   s01,
    input  logic [bfs_pkg::VALUE_W-1:0]   s10,
    input  logic [bfs_pkg::VALUE_W-1:0]   s11,
    input  logic [bfs_pkg::FRAC_W-1:0]    wcx,
    input  logic [bfs_pkg::FRAC_W-1:0]    wcy,
    bfs_out_if.source                     rsp
);
    import bfs_pkg::*;

    localparam int W_W   = FRAC_W + 1;
    localparam int MP_W  = VALUE_W + W_W;
    localparam int SUM_W = VALUE_W + 2;
    localparam logic [W_W-1:0]   ONE      = W_W'(1 << FRAC_W);
    localparam logic [MP_W-1:0]  HALF     = MP_W'(1 << (FRAC_W - 1));
    localparam logic [SUM_W-1:0] SAT_LIM  = SUM_W'((1 << VALUE_W) - 1);

    function automatic logic [VALUE_W-1:0] mul_round(input logic [VALUE_W-1:0] a,
                                                     input logic [W_W-1:0] w);
        logic [MP_W-1:0] p;
        p = MP_W'(a) * MP_W'(w) + HALF;
        return p[FRAC_W+VALUE_W-1:FRAC_W];
    endfunction

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    logic [W_W-1:0]     wcy_e, wfy, wcx1_e, wfx1;
    logic [VALUE_W-1:0] t00_reg, t10_reg, t01_reg, t11_reg;
    logic [FRAC_W-1:0]  wcx1_reg;
    logic [VALUE_W-1:0] u00_reg, u10_reg, u01_reg, u11_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [VALUE_W-1:0] out_reg;

    assign en3      = !v3_reg || rsp.ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign up_ready = en1;

    assign wcy_e  = W_W'(wcy);
    assign wfy    = ONE - wcy_e;
    assign wcx1_e = W_W'(wcx1_reg);
    assign wfx1   = ONE - wcx1_e;

    assign sum_next = SUM_W'(u00_reg) + SUM_W'(u10_reg) + SUM_W'(u01_reg) + SUM_W'(u11_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) begin
            t00_reg  <= mul_round(s00, wfy);
            t10_reg  <= mul_round(s10, wfy);
            t01_reg  <= mul_round(s01, wcy_e);
            t11_reg  <= mul_round(s11, wcy_e);
            wcx1_reg <= wcx;
        end
        if (en2) begin
            u00_reg <= mul_round(t00_reg, wfx1);
            u10_reg <= mul_round(t10_reg, wcx1_e);
            u01_reg <= mul_round(t01_reg, wfx1);
            u11_reg <= mul_round(t11_reg, wcx1_e);
        end
        if (en3) begin
            out_reg <= (sum_next > SAT_LIM) ? SAT_LIM[VALUE_W-1:0] : sum_next[VALUE_W-1:0];
        end
    end

    assign rsp.valid        = v3_reg;
    assign rsp.sample_value = out_reg;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bilinear field sampler testbench
// Streams grid writes and sample requests into the sampler, predicts each
// blended value from a local copy of the grids and checks every result in
// order. Both channels idle at random and the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
    import bfs_pkg::*;

    localparam int FIELDS      = FIELD_COUNT_DEF;
    localparam int SIDE        = GRID_SIDE_DEF;
    localparam int CELLS       = SIDE * SIDE;
    localparam int STORE_WORDS = FIELDS * CELLS;

    // Stop the random part at roughly this many request transactions.
    localparam int ITEM_TARGET   = 450;
    // Upper bound on the run before the watchdog ends it.
    localparam int CYCLE_LIMIT   = 300000;
    // Nine pipeline stages; settle a little longer to catch stray results.
    localparam int SETTLE_CYCLES = 30;

    localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        op_t                       op;
        logic [FIELD_W-1:0]        field;
        logic [ADDR_W-1:0]         addr;
        logic [VALUE_W-1:0]        value;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] scale;
        int                        gap;    // idle cycles before this transaction
        bit                        drain;  // hold until every result is back
    } req_item_t;

    // Floor and ceiling cells of both axes with their blend weights.
    typedef struct {
        int          fx;
        int          kx;
        int          fy;
        int          ky;
        logic [16:0] wfx;
        logic [16:0] wcx;
        logic [16:0] wfy;
        logic [16:0] wcy;
    } cell_taps_t;

    logic clk = 1'b0;
    logic rst_n;

    bfs_in_if  req_if ();
    bfs_out_if rsp_if ();

    bilinear_field_sampler_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Requests still to be driven, filled up front by the stimulus block.
    req_item_t         pending_reqs[$];
    // Blended values predicted for accepted samples, oldest first.
    logic [VALUE_W-1:0] predicted_samples[$];
    // Grid contents as the block should hold them after each accepted write.
    logic [VALUE_W-1:0] grid_copy[0:STORE_WORDS-1];
    // Words already scheduled for a write; a sample never reads any other.
    bit                 word_loaded[0:STORE_WORDS-1];

    req_item_t head_item;
    int        issued_count   = 0;
    int        total_items    = 0;
    int        accepted_count = 0;
    int        idle_left      = 0;
    int        stall_left     = 0;
    int        errors         = 0;
    int        cycle_count    = 0;
    bit        drain_next     = 1'b0;

    // ------------------------------------------------------------------------
    // Arithmetic of the predictor
    // ------------------------------------------------------------------------

    // Signed Q16.16 product, rounded half up, saturated to 32 bits.
    function automatic logic signed [COORD_W-1:0] scale_mul(
        logic signed [COORD_W-1:0] a,
        logic signed [COORD_W-1:0] b
    );
        longint prod;
        longint q;
        prod = longint'(a) * longint'(b);
        if (prod >= (longint'(1) <<< 47) || prod < -(longint'(1) <<< 47))
            return ((a >= 0) == (b >= 0)) ? Q_MAX : Q_MIN;
        if (prod < 0)
            prod = prod - 1;
        q = (prod >>> FRAC_W) + (prod[FRAC_W-1] ? 64'sd1 : 64'sd0);
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[COORD_W-1:0];
    endfunction

    // Magnitude of the scaled coordinate; the most negative value saturates.
    function automatic logic [COORD_W-1:0] scaled_abs(
        logic signed [COORD_W-1:0] coord,
        logic signed [COORD_W-1:0] scale
    );
        logic signed [COORD_W-1:0] m;
        m = scale_mul(coord, scale);
        if (m == Q_MIN)
            return 32'h7FFF_FFFF;
        if (m < 0)
            return -m;
        return m;
    endfunction

    // Unsigned Q16.16 product, rounded half up.
    function automatic logic [31:0] frac_mul(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'((p + 64'h8000) >> FRAC_W);
    endfunction

    function automatic cell_taps_t sample_taps(
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] scale
    );
        cell_taps_t  t;
        logic [31:0] cx;
        logic [31:0] cy;
        cx = scaled_abs(x, scale);
        cy = scaled_abs(y, scale);
        // Floor and ceiling wrap around the grid edge.
        t.fx  = (cx >> FRAC_W) % SIDE;
        t.fy  = (cy >> FRAC_W) % SIDE;
        t.kx  = ((cx >> FRAC_W) + (cx[FRAC_W-1:0] != 0)) % SIDE;
        t.ky  = ((cy >> FRAC_W) + (cy[FRAC_W-1:0] != 0)) % SIDE;
        t.wcx = {1'b0, cx[FRAC_W-1:0]};
        t.wcy = {1'b0, cy[FRAC_W-1:0]};
        t.wfx = 17'h1_0000 - t.wcx;
        t.wfy = 17'h1_0000 - t.wcy;
        return t;
    endfunction

    // Blend the four neighbours of a sample and saturate to 16 bits.
    function automatic logic [VALUE_W-1:0] blend_sample(
        logic [FIELD_W-1:0]        field,
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] scale
    );
        cell_taps_t  t;
        int          base;
        logic [31:0] acc;
        t    = sample_taps(x, y, scale);
        base = (int'(field) % FIELDS) * CELLS;
        acc  = frac_mul(frac_mul(grid_copy[base + t.fx * SIDE + t.fy], t.wfy), t.wfx)
             + frac_mul(frac_mul(grid_copy[base + t.kx * SIDE + t.fy], t.wfy), t.wcx)
             + frac_mul(frac_mul(grid_copy[base + t.fx * SIDE + t.ky], t.wcy), t.wfx)
             + frac_mul(frac_mul(grid_copy[base + t.kx * SIDE + t.ky], t.wcy), t.wcx);
        return (acc > 32'h0000_FFFF) ? 16'hFFFF : acc[VALUE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long. Every third
    // stretch of sixty transactions runs back to back with no idling at all.
    function automatic int pick_idle(int n);
        int r;
        r = $urandom_range(0, 99);
        if ((n / 60) % 3 == 2)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Grid words lean towards the top of the range so the blend saturates.
    function automatic logic [VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'hFFFF;
        if (r < 25)
            return 16'h0000;
        if (r < 45)
            return 16'(16'hFF00 | $urandom_range(0, 255));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_edge_coord();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_edge_scale();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    // Fill the payload fields with random values, so unused payload toggles too.
    function automatic req_item_t random_item();
        req_item_t it;
        it.op    = OP_WRITE;
        it.field = $urandom_range(0, FIELDS - 1);
        it.addr  = $urandom_range(0, CELLS - 1);
        it.value = $urandom_range(0, 65535);
        it.x     = $urandom;
        it.y     = $urandom;
        it.scale = $urandom;
        it.gap   = 0;
        it.drain = 1'b0;
        return it;
    endfunction

    task automatic enqueue(req_item_t it);
        it.gap     = pick_idle(issued_count);
        it.drain   = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(it);
        issued_count++;
    endtask

    task automatic push_write(
        logic [FIELD_W-1:0] field,
        logic [ADDR_W-1:0]  addr,
        logic [VALUE_W-1:0] value
    );
        req_item_t it;
        it       = random_item();
        it.op    = OP_WRITE;
        it.field = field;
        it.addr  = addr;
        it.value = value;
        word_loaded[int'(field) * CELLS + int'(addr)] = 1'b1;
        enqueue(it);
    endtask

    // Load any neighbour not yet written, then issue the sample itself.
    task automatic push_sample(
        logic [FIELD_W-1:0]        field,
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] scale
    );
        req_item_t  it;
        cell_taps_t t;
        int         rows[4];
        int         cols[4];
        t    = sample_taps(x, y, scale);
        rows = '{t.fx, t.kx, t.fx, t.kx};
        cols = '{t.fy, t.fy, t.ky, t.ky};
        for (int i = 0; i < 4; i++)
        begin
            if (!word_loaded[int'(field) * CELLS + rows[i] * SIDE + cols[i]])
                push_write(field, ADDR_W'(rows[i] * SIDE + cols[i]), pick_word());
        end
        it       = random_item();
        it.op    = OP_SAMPLE;
        it.field = field;
        it.x     = x;
        it.y     = y;
        it.scale = scale;
        enqueue(it);
    endtask

    // ------------------------------------------------------------------------
    // Request driver and predictor
    // ------------------------------------------------------------------------
    // On every accepted transaction, update the grid copy or predict the
    // blended value; then either hold the current transaction, idle, or
    // present the next one. A transaction marked for draining waits until
    // every predicted result has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            idle_left    <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                accepted_count++;
                if (req_if.op == OP_WRITE)
                    grid_copy[(int'(req_if.field_index) % FIELDS) * CELLS
                              + int'(req_if.cell_addr) % CELLS] = req_if.cell_value;
                else
                    predicted_samples.push_back(blend_sample(req_if.field_index,
                        req_if.coord_x, req_if.coord_y, req_if.coord_scale));
            end

            if (req_if.valid && !req_if.ready)
            begin
                // Hold the transaction until the block takes it.
            end
            else if (idle_left > 0)
            begin
                req_if.valid <= 1'b0;
                idle_left    <= idle_left - 1;
            end
            else if (pending_reqs.size() == 0)
                req_if.valid <= 1'b0;
            else if (pending_reqs[0].gap > 0)
            begin
                req_if.valid        <= 1'b0;
                idle_left           <= pending_reqs[0].gap - 1;
                pending_reqs[0].gap  = 0;
            end
            else if (pending_reqs[0].drain && predicted_samples.size() != 0)
                req_if.valid <= 1'b0;
            else
            begin
                head_item           = pending_reqs.pop_front();
                req_if.valid       <= 1'b1;
                req_if.op          <= head_item.op;
                req_if.field_index <= head_item.field;
                req_if.cell_addr   <= head_item.addr;
                req_if.cell_value  <= head_item.value;
                req_if.coord_x     <= head_item.x;
                req_if.coord_y     <= head_item.y;
                req_if.coord_scale <= head_item.scale;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and back-pressure
    // ------------------------------------------------------------------------
    // Check each accepted result against the oldest prediction, then decide
    // whether to stall the result channel. One window of every four starts no new
    // stalls, so ready stays high once any stall in progress ends.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (predicted_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample_value, expected none, got %04h",
                             $time, rsp_if.sample_value);
                    errors++;
                end
                else if (rsp_if.sample_value !== predicted_samples[0])
                begin
                    $display("%0t: sample_value mismatch, expected %04h, got %04h",
                             $time, predicted_samples[0], rsp_if.sample_value);
                    errors++;
                    void'(predicted_samples.pop_front());
                end
                else
                    void'(predicted_samples.pop_front());
            end

            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if ((cycle_count / 500) % 4 == 3 || $urandom_range(0, 99) < 70)
                rsp_if.ready <= 1'b1;
            else
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                           : $urandom_range(8, 40);
            end
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int                        r;
        int                        m;
        logic [FIELD_W-1:0]        fld;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sc;

        // Known values on every block input from time zero.
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.op          = OP_WRITE;
        req_if.field_index = '0;
        req_if.cell_addr   = '0;
        req_if.cell_value  = '0;
        req_if.coord_x     = '0;
        req_if.coord_y     = '0;
        req_if.coord_scale = '0;
        rsp_if.ready       = 1'b0;

        // Directed part. Saturate a 2x2 patch of field 0 for blend overflow,
        // and touch the corners of the address, field and value ranges.
        push_write(2'd0, 10'd0, 16'hFFFF);
        push_write(2'd0, 10'd1, 16'hFFFF);
        push_write(2'd0, 10'd32, 16'hFFFF);
        push_write(2'd0, 10'd33, 16'hFFFF);
        push_write(2'd3, 10'd1023, 16'h0000);
        push_write(2'd1, 10'd512, 16'hA55A);
        // Integer coordinate: all four taps on one cell.
        push_sample(2'd0, '0, '0, Q_ONE);
        // Half-way between four full-scale words: the sum overflows.
        push_sample(2'd0, 32'sh0000_8000, 32'sh0000_8000, Q_ONE);
        // Scale overflow to both rails; the ceiling wraps past the last row.
        push_sample(2'd3, Q_MAX, Q_MIN, Q_MAX);
        // Most negative product, and a negative fractional coordinate.
        push_sample(2'd2, Q_MIN, -32'sh0001_4000, Q_ONE);
        // Zero scale, then a negative scale.
        push_sample(2'd1, $urandom, $urandom, '0);
        push_sample(2'd1, 32'sh0003_C000, -32'sh0002_8000, -32'sh0001_8000);

        // Random part: let the pipeline empty before it starts.
        drain_next = 1'b1;
        while (issued_count < ITEM_TARGET)
        begin
            // Drain the pipeline again now and then, mid-stream.
            if (issued_count % 150 < 5 && $urandom_range(0, 19) == 0)
                drain_next = 1'b1;
            r   = $urandom_range(0, 99);
            fld = $urandom_range(0, FIELDS - 1);
            if (r < 25)
            begin
                // Rewrite a word, mostly near the origin where samples land.
                if ($urandom_range(0, 1) == 0)
                    push_write(fld, ADDR_W'($urandom_range(0, 9 * SIDE - 1)), pick_word());
                else
                    push_write(fld, ADDR_W'($urandom_range(0, CELLS - 1)), pick_word());
            end
            else
            begin
                m = $urandom_range(0, 9);
                if (m < 6)
                begin
                    // Typical use: small coordinates around the origin.
                    sx = int'($urandom_range(0, 12 << FRAC_W)) - (4 << FRAC_W);
                    sy = int'($urandom_range(0, 12 << FRAC_W)) - (4 << FRAC_W);
                    case ($urandom_range(0, 2))
                        0:       sc = Q_ONE;
                        1:       sc = $urandom_range(32'h0000_4000, 32'h0002_0000);
                        default: sc = -int'($urandom_range(32'h0000_4000, 32'h0002_0000));
                    endcase
                end
                else if (m < 8)
                begin
                    // Full-range coordinates with a modest scale.
                    sx = $urandom;
                    sy = $urandom;
                    sc = ($urandom_range(0, 1) == 0) ? Q_ONE
                                                     : $urandom_range(0, 32'h0003_FFFF);
                end
                else
                begin
                    sx = pick_edge_coord();
                    sy = pick_edge_coord();
                    sc = pick_edge_scale();
                end
                push_sample(fld, sx, sy, sc);
            end
        end
        total_items = issued_count;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items)
            @(posedge clk);
        while (predicted_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
